FILE: sv/tsq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tsq_pkg: shared types and constants for tilt steering
// Sequencer states, unit request bundles, register indexes, CORDIC angle
// table and the elaboration-time builder for the smoothing coefficient table.
// ---------------------------------------------------------------------------
package tsq_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_PREP,
		ST_CORD1,
		ST_GAIN,
		ST_GAINW,
		ST_CORD2,
		ST_APPLY,
		ST_DIV,
		ST_ALPHA,
		ST_ALPHAW,
		ST_FILTM,
		ST_FILTW,
		ST_DONE
	} state_t;

	// Start request for the shared CORDIC vectoring unit
	typedef struct packed {
		logic               start;
		logic signed [31:0] x;
		logic signed [31:0] y;
	} cord_req_t;

	// Start request for the iterative divider
	typedef struct packed {
		logic        start;
		logic [13:0] num;
		logic [13:0] den;
	} div_req_t;

	localparam logic OP_UPDATE  = 1'b0;
	localparam logic OP_CAPTURE = 1'b1;

	localparam logic [1:0] REG_ENABLE     = 2'd0;
	localparam logic [1:0] REG_INVERT     = 2'd1;
	localparam logic [1:0] REG_DEADZONE   = 2'd2;
	localparam logic [1:0] REG_FULL_SCALE = 2'd3;

	localparam logic [13:0] FULL_SCALE_RESET = 14'd1920;

	localparam int DIV_STEPS = 22;
	localparam int ATAN_N    = 24;

	localparam logic [31:0] INV_GAIN_Q30 = 32'd652032874;

	// atan(2^-i) in 2^-22 degree
	localparam logic [28:0] ATAN_DEG22 [ATAN_N] = '{
		29'd188743680, 29'd111421900, 29'd58872272, 29'd29884485,
		29'd15000234,  29'd7507429,   29'd3754631,  29'd1877430,
		29'd938729,    29'd469366,    29'd234683,   29'd117342,
		29'd58671,     29'd29335,     29'd14668,    29'd7334,
		29'd3667,      29'd1833,      29'd917,      29'd458,
		29'd229,       29'd115,       29'd57,       29'd29
	};

	localparam logic signed [15:0] ROLL_LIMIT = 16'sd5760;
	localparam logic signed [15:0] HALF_TURN  = 16'sd11520;
	localparam logic signed [15:0] FULL_TURN  = 16'sd23040;
	localparam logic signed [25:0] UNIT_Q22   = 26'sd4194304;
	localparam logic signed [18:0] STEER_MAX  = 19'sd32767;

	// 1 - ef^k in Q30 by repeated rounded multiplication
	function automatic logic [30:0] alpha_entry(longint ef, int k);
		longint e;
		e = longint'(1) <<< 30;
		for (int i = 0; i < k; i++) begin
			e = (e * ef + (longint'(1) <<< 29)) >>> 30;
		end
		return 31'((longint'(1) <<< 30) - e);
	endfunction

endpackage
`default_nettype wire

FILE: sv/tsq_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tsq_mul: shared signed multiplier
// 32x32 signed multiply with the product registered.
// ---------------------------------------------------------------------------
module tsq_mul (
	input  wire logic               clk,
	input  wire logic signed [31:0] a,
	input  wire logic signed [31:0] b,
	output logic signed [63:0]      p
);

	// product registered from the operands
	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule
`default_nettype wire

FILE: sv/tsq_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tsq_cordic: iterative CORDIC vectoring unit
// One micro-rotation per cycle; drives y to zero, accumulates angle in z.
// ---------------------------------------------------------------------------
module tsq_cordic #(
	parameter int STEPS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tsq_pkg::cord_req_t  req,
	output logic                     done,
	output logic signed [31:0]       x_out,
	output logic signed [31:0]       z_out
);

	localparam int CW = $clog2(STEPS + 1);

	logic [CW-1:0]      cnt_q;
	logic               busy_q;
	logic               done_q;
	logic signed [31:0] x_q;
	logic signed [31:0] y_q;
	logic signed [31:0] z_q;
	logic signed [31:0] dx;
	logic signed [31:0] dy;
	logic signed [31:0] dz;

	// shifted terms for this step
	always_comb begin
		dx = y_q >>> cnt_q;
		dy = x_q >>> cnt_q;
		dz = 32'(tsq_pkg::ATAN_DEG22[5'(cnt_q)]);
	end

	// step counter, held at the last step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q == CW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// rotation datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= req.x;
			y_q <= req.y;
			z_q <= '0;
		end else if (busy_q) begin
			if (!y_q[31]) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + dz;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - dz;
			end
		end
	end

	assign done  = done_q;
	assign x_out = x_q;
	assign z_out = z_q;

endmodule
`default_nettype wire

FILE: sv/tsq_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tsq_div: restoring divider, one quotient bit per cycle
// Computes (num * 2^22 + den/2) / den for num < den.
// ---------------------------------------------------------------------------
module tsq_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tsq_pkg::div_req_t  req,
	output logic                    done,
	output logic [21:0]             quot
);

	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [13:0] rem_q;
	logic [13:0] den_q;
	logic [21:0] low_q;
	logic [21:0] quot_q;
	logic [14:0] trial;
	logic        ge;
	logic [13:0] nrem;

	// one compare and subtract
	always_comb begin
		trial = {rem_q, low_q[21]};
		ge    = trial >= {1'b0, den_q};
		nrem  = ge ? 14'(trial - {1'b0, den_q}) : trial[13:0];
	end

	// bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'(tsq_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			den_q <= req.den;
			low_q <= {9'd0, req.den[13:1]};
		end else if (busy_q) begin
			rem_q  <= nrem;
			low_q  <= {low_q[20:0], 1'b0};
			quot_q <= {quot_q[20:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire

FILE: sv/tilt_steer_from_quaternion.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence, accept to next accept: an update item runs the products, the first
//   CORDIC pass, gain correction, the second pass (skipped at zero roll), the
//   divider (skipped when not needed) and the filter; a capture item stops before
//   the divider. All run in sequence on one shared set of units.
// Throughput: one item at a time; s_tready is high only when the sequencer idles.
// Reset: arst_n resets registers (full scale to 1920), rest roll, filter state and output valid.
// ---------------------------------------------------------------------------
// tilt_steer_from_quaternion: roll-based steering from orientation
// Rotates the body right axis, takes roll by CORDIC, applies rest offset,
// deadzone, scaling, inversion and a first-order low-pass.
// ---------------------------------------------------------------------------
module tilt_steer_from_quaternion #(
	parameter int ALPHA_TABLE_DEPTH = 256,
	parameter int CORDIC_STEPS      = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// item in
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,   // quat_x, quat_y, quat_z, quat_w, step_time
	input  wire logic [0:0]  s_tuser,   // operation
	// item out
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // tilt_angle[14:0], steer_value[30:15], active[31]
	// register writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [13:0] cfg_data
);

	localparam int     TW        = $clog2(ALPHA_TABLE_DEPTH + 1);
	localparam longint AlphaDen  = longint'(ALPHA_TABLE_DEPTH) * 50000;
	localparam longint AlphaStep = ((longint'(1) <<< 46) + AlphaDen / 2) / AlphaDen;

	// exp(-step) in Q30 from a 12-term series
	localparam longint OneQ30  = longint'(1) <<< 30;
	localparam longint HalfQ30 = longint'(1) <<< 29;
	localparam longint ExpT1   = ((OneQ30 * AlphaStep + HalfQ30) >>> 30) / 1;
	localparam longint ExpT2   = (((ExpT1 * AlphaStep + HalfQ30) >>> 30) + 1) / 2;
	localparam longint ExpT3   = (((ExpT2 * AlphaStep + HalfQ30) >>> 30) + 1) / 3;
	localparam longint ExpT4   = (((ExpT3 * AlphaStep + HalfQ30) >>> 30) + 2) / 4;
	localparam longint ExpT5   = (((ExpT4 * AlphaStep + HalfQ30) >>> 30) + 2) / 5;
	localparam longint ExpT6   = (((ExpT5 * AlphaStep + HalfQ30) >>> 30) + 3) / 6;
	localparam longint ExpT7   = (((ExpT6 * AlphaStep + HalfQ30) >>> 30) + 3) / 7;
	localparam longint ExpT8   = (((ExpT7 * AlphaStep + HalfQ30) >>> 30) + 4) / 8;
	localparam longint ExpT9   = (((ExpT8 * AlphaStep + HalfQ30) >>> 30) + 4) / 9;
	localparam longint ExpT10  = (((ExpT9 * AlphaStep + HalfQ30) >>> 30) + 5) / 10;
	localparam longint ExpT11  = (((ExpT10 * AlphaStep + HalfQ30) >>> 30) + 5) / 11;
	localparam longint ExpT12  = (((ExpT11 * AlphaStep + HalfQ30) >>> 30) + 6) / 12;
	localparam longint ExpFactor = OneQ30 - ExpT1 + ExpT2 - ExpT3 + ExpT4 - ExpT5
		+ ExpT6 - ExpT7 + ExpT8 - ExpT9 + ExpT10 - ExpT11 + ExpT12;

	// smoothing coefficient table
	logic [30:0] alpha_rom [ALPHA_TABLE_DEPTH + 1];
	for (genvar k = 0; k <= ALPHA_TABLE_DEPTH; k++) begin : g_alpha
		assign alpha_rom[k] = tsq_pkg::alpha_entry(ExpFactor, k);
	end

	tsq_pkg::state_t state_q, state_d;

	// configuration
	logic        enable_q;
	logic        invert_q;
	logic [13:0] deadzone_q;
	logic [13:0] full_scale_q;

	// persistent state
	logic signed [14:0] rest_q;
	logic               captured_q;
	logic signed [14:0] last_angle_q;
	logic signed [23:0] sv_q;

	// item and working registers
	logic               op_q;
	logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
	logic [15:0]        t_q;
	logic [2:0]         k_q;
	logic signed [31:0] s0_q, s1_q, s2_q;
	logic signed [31:0] r1_q;
	logic signed [14:0] roll_q;
	logic [22:0]        q_q;
	logic               neg_q;
	logic [30:0]        alpha_q;
	logic               m_tvalid_q;
	logic [31:0]        m_tdata_q;

	// unit hookups
	logic signed [31:0]  mul_a, mul_b;
	logic signed [63:0]  mul_p;
	tsq_pkg::cord_req_t  cord_req;
	logic                cord_done;
	logic signed [31:0]  cord_x, cord_z;
	tsq_pkg::div_req_t   div_req;
	logic                div_done;
	logic [21:0]         div_quot;

	tsq_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	tsq_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cord_req),
		.done   (cord_done),
		.x_out  (cord_x),
		.z_out  (cord_z)
	);

	tsq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	// rotated axis start values
	logic signed [31:0] r0_sh, r0_mag, r2_sh;
	always_comb begin
		r0_sh  = (32'sd134217728 - s0_q) >>> 3;
		r0_mag = r0_sh[31] ? -r0_sh : r0_sh;
		r2_sh  = s2_q >>> 3;
	end

	// horizontal length after gain correction
	logic signed [63:0] h_sum;
	logic signed [31:0] h_val;
	logic               roll_zero;
	always_comb begin
		h_sum     = mul_p + 64'sd536870912;
		h_val     = 32'(h_sum >>> 30);
		roll_zero = (h_val == 32'sd0) && (r1_q == 32'sd0);
	end

	// roll in 1/64 degree, clamped
	logic signed [31:0] z_sum;
	logic signed [15:0] z_rnd;
	logic signed [14:0] roll_new;
	always_comb begin
		z_sum = cord_z + 32'sd32768;
		z_rnd = 16'(z_sum >>> 16);
		if (z_rnd > tsq_pkg::ROLL_LIMIT) begin
			roll_new = 15'(tsq_pkg::ROLL_LIMIT);
		end else if (z_rnd < -tsq_pkg::ROLL_LIMIT) begin
			roll_new = 15'(-tsq_pkg::ROLL_LIMIT);
		end else begin
			roll_new = 15'(z_rnd);
		end
	end

	// relative angle, wrap, deadzone and scale decision
	logic signed [15:0] ang_raw, ang_w;
	logic signed [14:0] ang;
	logic [13:0]        mag;
	logic [13:0]        fs_eff;
	logic               steer_on;
	logic               go_div;
	always_comb begin
		ang_raw = 16'(roll_q) - 16'(rest_q);
		ang_w   = ang_raw;
		if (ang_raw > tsq_pkg::HALF_TURN) begin
			ang_w = ang_raw - tsq_pkg::FULL_TURN;
		end else if (ang_raw < -tsq_pkg::HALF_TURN) begin
			ang_w = ang_raw + tsq_pkg::FULL_TURN;
		end
		ang      = 15'(ang_w);
		mag      = ang[14] ? 14'(-ang) : 14'(ang);
		fs_eff   = (full_scale_q == 14'd0) ? 14'd1 : full_scale_q;
		steer_on = captured_q && (mag > deadzone_q);
		go_div   = steer_on && (mag < fs_eff);
	end

	// coefficient lookup
	logic [TW+15:0] pos;
	logic [TW-1:0]  idx;
	logic [15:0]    frac;
	logic [30:0]    diff;
	always_comb begin
		pos  = (TW + 16)'(t_q) * (TW + 16)'(ALPHA_TABLE_DEPTH);
		idx  = pos[TW+15:16];
		frac = pos[15:0];
		diff = alpha_rom[idx + 1'b1] - alpha_rom[idx];
	end

	// signed target and filter error
	logic signed [23:0] tgt_pos, tgt;
	logic signed [24:0] delta;
	always_comb begin
		tgt_pos = 24'(q_q);
		tgt     = (neg_q ^ invert_q) ? -tgt_pos : tgt_pos;
		delta   = 25'(tgt) - 25'(sv_q);
	end

	// filter update with clamp
	logic signed [63:0] f_sum;
	logic signed [25:0] f_step, sv_sum;
	logic signed [23:0] sv_new;
	always_comb begin
		f_sum  = mul_p + 64'sd536870912;
		f_step = 26'(f_sum >>> 30);
		sv_sum = 26'(sv_q) + f_step;
		if (sv_sum > tsq_pkg::UNIT_Q22) begin
			sv_new = 24'(tsq_pkg::UNIT_Q22);
		end else if (sv_sum < -tsq_pkg::UNIT_Q22) begin
			sv_new = 24'(-tsq_pkg::UNIT_Q22);
		end else begin
			sv_new = 24'(sv_sum);
		end
	end

	// output steering value
	logic signed [25:0] st_sum;
	logic signed [18:0] st_sh;
	logic signed [15:0] steer;
	logic               out_free;
	always_comb begin
		st_sum = 26'(sv_q) + 26'sd64;
		st_sh  = 19'(st_sum >>> 7);
		if (st_sh > tsq_pkg::STEER_MAX) begin
			steer = 16'(tsq_pkg::STEER_MAX);
		end else if (st_sh < -tsq_pkg::STEER_MAX) begin
			steer = 16'(-tsq_pkg::STEER_MAX);
		end else begin
			steer = 16'(st_sh);
		end
		out_free = !m_tvalid_q || m_tready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tsq_pkg::ST_IDLE:   if (s_tvalid) state_d = tsq_pkg::ST_MUL;
			tsq_pkg::ST_MUL:    if (k_q == 3'd6) state_d = tsq_pkg::ST_PREP;
			tsq_pkg::ST_PREP:   state_d = tsq_pkg::ST_CORD1;
			tsq_pkg::ST_CORD1:  if (cord_done) state_d = tsq_pkg::ST_GAIN;
			tsq_pkg::ST_GAIN:   state_d = tsq_pkg::ST_GAINW;
			tsq_pkg::ST_GAINW: begin
				state_d = roll_zero ? tsq_pkg::ST_APPLY : tsq_pkg::ST_CORD2;
			end
			tsq_pkg::ST_CORD2:  if (cord_done) state_d = tsq_pkg::ST_APPLY;
			tsq_pkg::ST_APPLY: begin
				if (op_q == tsq_pkg::OP_CAPTURE) begin
					state_d = tsq_pkg::ST_DONE;
				end else if (go_div) begin
					state_d = tsq_pkg::ST_DIV;
				end else begin
					state_d = tsq_pkg::ST_ALPHA;
				end
			end
			tsq_pkg::ST_DIV:    if (div_done) state_d = tsq_pkg::ST_ALPHA;
			tsq_pkg::ST_ALPHA:  state_d = tsq_pkg::ST_ALPHAW;
			tsq_pkg::ST_ALPHAW: state_d = tsq_pkg::ST_FILTM;
			tsq_pkg::ST_FILTM:  state_d = tsq_pkg::ST_FILTW;
			tsq_pkg::ST_FILTW:  state_d = tsq_pkg::ST_DONE;
			tsq_pkg::ST_DONE:   if (out_free) state_d = tsq_pkg::ST_IDLE;
			default:            state_d = tsq_pkg::ST_IDLE;
		endcase
	end

	// state outputs: handshake, unit requests, multiplier operands
	always_comb begin
		s_tready     = 1'b0;
		cord_req     = '0;
		div_req      = '0;
		mul_a        = '0;
		mul_b        = '0;
		case (state_q)
			tsq_pkg::ST_IDLE: s_tready = 1'b1;
			tsq_pkg::ST_MUL: begin
				case (k_q)
					3'd0:    begin mul_a = 32'(qy_q); mul_b = 32'(qy_q); end
					3'd1:    begin mul_a = 32'(qz_q); mul_b = 32'(qz_q); end
					3'd2:    begin mul_a = 32'(qw_q); mul_b = 32'(qz_q); end
					3'd3:    begin mul_a = 32'(qx_q); mul_b = 32'(qy_q); end
					3'd4:    begin mul_a = 32'(qx_q); mul_b = 32'(qz_q); end
					default: begin mul_a = 32'(qw_q); mul_b = 32'(qy_q); end
				endcase
			end
			tsq_pkg::ST_PREP: begin
				cord_req.start = 1'b1;
				cord_req.x     = r0_mag;
				cord_req.y     = r2_sh;
			end
			tsq_pkg::ST_GAIN: begin
				mul_a = cord_x;
				mul_b = tsq_pkg::INV_GAIN_Q30;
			end
			tsq_pkg::ST_GAINW: begin
				cord_req.start = !roll_zero;
				cord_req.x     = h_val;
				cord_req.y     = r1_q;
			end
			tsq_pkg::ST_APPLY: begin
				div_req.start = (op_q == tsq_pkg::OP_UPDATE) && go_div;
				div_req.num   = mag;
				div_req.den   = fs_eff;
			end
			tsq_pkg::ST_ALPHA: begin
				mul_a = 32'(diff);
				mul_b = 32'(frac);
			end
			tsq_pkg::ST_FILTM: begin
				mul_a = 32'(alpha_q);
				mul_b = 32'(delta);
			end
			default: ;
		endcase
	end

	// control and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tsq_pkg::ST_IDLE;
			k_q          <= '0;
			enable_q     <= 1'b0;
			invert_q     <= 1'b0;
			deadzone_q   <= '0;
			full_scale_q <= tsq_pkg::FULL_SCALE_RESET;
			rest_q       <= '0;
			captured_q   <= 1'b0;
			last_angle_q <= '0;
			sv_q         <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					tsq_pkg::REG_ENABLE:     enable_q     <= cfg_data[0];
					tsq_pkg::REG_INVERT:     invert_q     <= cfg_data[0];
					tsq_pkg::REG_DEADZONE:   deadzone_q   <= cfg_data;
					tsq_pkg::REG_FULL_SCALE: full_scale_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == tsq_pkg::ST_IDLE) begin
				k_q <= '0;
			end else if (state_q == tsq_pkg::ST_MUL) begin
				k_q <= k_q + 1'b1;
			end
			if (state_q == tsq_pkg::ST_APPLY) begin
				if (op_q == tsq_pkg::OP_CAPTURE) begin
					rest_q     <= roll_q;
					captured_q <= 1'b1;
				end else begin
					last_angle_q <= ang;
				end
			end
			if (state_q == tsq_pkg::ST_FILTW) begin
				sv_q <= sv_new;
			end
			// result valid: set on a new result, cleared when taken
			if (state_q == tsq_pkg::ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// working datapath
	always_ff @(posedge clk) begin
		case (state_q)
			tsq_pkg::ST_IDLE: begin
				op_q <= s_tuser[0];
				qx_q <= s_tdata[15:0];
				qy_q <= s_tdata[31:16];
				qz_q <= s_tdata[47:32];
				qw_q <= s_tdata[63:48];
				t_q  <= s_tdata[79:64];
			end
			tsq_pkg::ST_MUL: begin
				case (k_q)
					3'd1:    s0_q <= mul_p[31:0];
					3'd2:    s0_q <= s0_q + mul_p[31:0];
					3'd3:    s1_q <= mul_p[31:0];
					3'd4:    s1_q <= s1_q + mul_p[31:0];
					3'd5:    s2_q <= mul_p[31:0];
					3'd6:    s2_q <= s2_q - mul_p[31:0];
					default: ;
				endcase
			end
			tsq_pkg::ST_PREP: r1_q <= s1_q >>> 3;
			tsq_pkg::ST_GAINW: if (roll_zero) roll_q <= '0;
			tsq_pkg::ST_CORD2: if (cord_done) roll_q <= roll_new;
			tsq_pkg::ST_APPLY: begin
				neg_q <= ang[14];
				if (!steer_on) begin
					q_q <= '0;
				end else if (!go_div) begin
					q_q <= 23'(tsq_pkg::UNIT_Q22);
				end
			end
			tsq_pkg::ST_DIV: if (div_done) q_q <= {1'b0, div_quot};
			tsq_pkg::ST_ALPHAW: begin
				if (t_q == 16'd0) begin
					alpha_q <= 31'h4000_0000;
				end else begin
					alpha_q <= alpha_rom[idx] + 31'(mul_p >>> 16);
				end
			end
			tsq_pkg::ST_DONE: begin
				if (out_free) begin
					m_tdata_q <= {enable_q & captured_q, steer, last_angle_q};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign cfg_ready = 1'b1;

endmodule
`default_nettype wire

FILE: sv/tsq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tsq_checker: port-level checks for tilt steering
// Busy after each item, held results, result field ranges.
// ---------------------------------------------------------------------------
module tsq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);

	// one item at a time: busy right after an accept
	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while item in flight");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed under stall");

	// steering is symmetric saturated
	a_steer_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[30:15] != 16'h8000)
		else $error("steer value out of range");

	// wrapped tilt stays within a half turn
	a_tilt_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[14:0]) <= 15'sd11520)
			&& ($signed(m_tdata[14:0]) >= -15'sd11520))
		else $error("tilt angle out of range");

endmodule

bind tilt_steer_from_quaternion tsq_checker u_tsq_checker (.*);
`default_nettype wire
